// ===== rtl/i2cms_pkg.sv =====
// Package: shared types and constants for the I2C master bit sequencer.
`timescale 1ns / 1ps
package i2cms_pkg;

	// Command codes carried by each tick
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_WACK  = 3'd4;
	localparam logic [2:0] CMD_READ  = 3'd5;

	// Configuration register indexes
	localparam logic CFG_TICKS_PER_US = 1'b0;
	localparam logic CFG_ACK_TIMEOUT  = 1'b1;

	// Configuration reset values
	localparam logic [7:0] TICKS_PER_US_RST = 8'd100;
	localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

	// Bits per byte on the bus
	localparam logic [3:0] BYTE_BITS = 4'd8;

	// Output buffer depth
	localparam logic [1:0] OBUF_DEPTH = 2'd2;

	// Pin sequence phases
	typedef enum logic [4:0] {
		PH_IDLE  = 5'd0,
		PH_ST0   = 5'd1,
		PH_ST1   = 5'd2,
		PH_ST2   = 5'd3,
		PH_SP0   = 5'd4,
		PH_SP1   = 5'd5,
		PH_SP2   = 5'd6,
		PH_AW0   = 5'd7,
		PH_AW1   = 5'd8,
		PH_AWP   = 5'd9,
		PH_WBIT  = 5'd10,
		PH_WHIGH = 5'd11,
		PH_WLOW  = 5'd12,
		PH_WEND  = 5'd13,
		PH_RLOW  = 5'd14,
		PH_RHIGH = 5'd15,
		PH_RK0   = 5'd16,
		PH_RK1   = 5'd17,
		PH_RK2   = 5'd18
	} phase_t;

	// Sequencer state
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  bit_index;
		logic [7:0]  shift_data;
		logic [9:0]  delay_left;
		logic [7:0]  poll_count;
		logic        ack_choice;
		logic        scl;
		logic        sda;
		logic        sda_dir;
		logic [7:0]  rx;
		logic        ack_fail;
	} state_t;

	// One result item
	typedef struct packed {
		logic        scl_level;
		logic        sda_level;
		logic        sda_is_output;
		logic        busy;
		logic        done;
		logic [7:0]  rx_byte;
		logic        ack_failed;
	} result_t;

endpackage

// ===== rtl/i2cms_step.sv =====
// Next-state and result logic for one tick of the I2C bit sequencer.
`timescale 1ns / 1ps
module i2cms_step (
	input  i2cms_pkg::state_t  st,
	input  logic [7:0]         ticks_per_us,
	input  logic [7:0]         ack_timeout,
	input  logic [2:0]         command,
	input  logic [7:0]         tx_byte,
	input  logic               send_ack,
	input  logic               sda_in,
	output i2cms_pkg::state_t  st_nxt,
	output i2cms_pkg::result_t res
);

	logic [9:0] dly1;
	logic [9:0] dly2;
	logic [9:0] dly4;
	logic [3:0] bit_inc;
	logic       active;

	// Delay lengths in ticks for 1, 2 and 4 us
	assign dly1 = {2'b00, ticks_per_us};
	assign dly2 = {1'b0, ticks_per_us, 1'b0};
	assign dly4 = {ticks_per_us, 2'b00};
	assign bit_inc = st.bit_index + 4'd1;

	// Command decode, then one delay count or one pin action
	always_comb begin
		st_nxt = st;
		active = 1'b0;
		if (st.phase == i2cms_pkg::PH_IDLE) begin
			st_nxt.delay_left = '0;
			case (command)
				i2cms_pkg::CMD_START: st_nxt.phase = i2cms_pkg::PH_ST0;
				i2cms_pkg::CMD_STOP:  st_nxt.phase = i2cms_pkg::PH_SP0;
				i2cms_pkg::CMD_WRITE: begin
					st_nxt.phase = i2cms_pkg::PH_WBIT;
					st_nxt.shift_data = tx_byte;
					st_nxt.bit_index = '0;
				end
				i2cms_pkg::CMD_WACK:  st_nxt.phase = i2cms_pkg::PH_AW0;
				i2cms_pkg::CMD_READ: begin
					st_nxt.phase = i2cms_pkg::PH_RLOW;
					st_nxt.shift_data = '0;
					st_nxt.bit_index = '0;
					st_nxt.ack_choice = send_ack;
				end
				default: ;
			endcase
		end

		if (st_nxt.phase != i2cms_pkg::PH_IDLE) begin
			active = 1'b1;
			if (st_nxt.delay_left != '0) begin
				st_nxt.delay_left = st_nxt.delay_left - 10'd1;
			end else begin
				case (st_nxt.phase)
					i2cms_pkg::PH_ST0: begin
						st_nxt.sda_dir = 1'b1;
						st_nxt.sda = 1'b1;
						st_nxt.scl = 1'b1;
						st_nxt.delay_left = dly4;
						st_nxt.phase = i2cms_pkg::PH_ST1;
					end
					i2cms_pkg::PH_ST1: begin
						st_nxt.sda = 1'b0;
						st_nxt.delay_left = dly4;
						st_nxt.phase = i2cms_pkg::PH_ST2;
					end
					i2cms_pkg::PH_ST2: begin
						st_nxt.scl = 1'b0;
						st_nxt.phase = i2cms_pkg::PH_IDLE;
					end
					i2cms_pkg::PH_SP0: begin
						st_nxt.sda_dir = 1'b1;
						st_nxt.sda = 1'b0;
						st_nxt.scl = 1'b1;
						st_nxt.delay_left = dly4;
						st_nxt.phase = i2cms_pkg::PH_SP1;
					end
					i2cms_pkg::PH_SP1: begin
						st_nxt.sda = 1'b1;
						st_nxt.delay_left = dly4;
						st_nxt.phase = i2cms_pkg::PH_SP2;
					end
					i2cms_pkg::PH_SP2: st_nxt.phase = i2cms_pkg::PH_IDLE;
					i2cms_pkg::PH_AW0: begin
						st_nxt.sda_dir = 1'b0;
						st_nxt.sda = 1'b1;
						st_nxt.poll_count = '0;
						st_nxt.delay_left = dly1;
						st_nxt.phase = i2cms_pkg::PH_AW1;
					end
					i2cms_pkg::PH_AW1: begin
						st_nxt.scl = 1'b1;
						st_nxt.delay_left = dly1;
						st_nxt.phase = i2cms_pkg::PH_AWP;
					end
					i2cms_pkg::PH_AWP: begin
						if (!sda_in) begin
							// slave acknowledged
							st_nxt.scl = 1'b0;
							st_nxt.ack_fail = 1'b0;
							st_nxt.phase = i2cms_pkg::PH_IDLE;
						end else if (st_nxt.poll_count >= ack_timeout) begin
							// timeout: flag and start the stop sequence now
							st_nxt.ack_fail = 1'b1;
							st_nxt.sda_dir = 1'b1;
							st_nxt.sda = 1'b0;
							st_nxt.scl = 1'b1;
							st_nxt.delay_left = dly4;
							st_nxt.phase = i2cms_pkg::PH_SP1;
						end else begin
							st_nxt.poll_count = st_nxt.poll_count + 8'd1;
						end
					end
					i2cms_pkg::PH_WBIT: begin
						st_nxt.sda_dir = 1'b1;
						st_nxt.scl = 1'b0;
						st_nxt.sda = st_nxt.shift_data[7];
						st_nxt.shift_data = {st_nxt.shift_data[6:0], 1'b0};
						st_nxt.delay_left = dly2;
						st_nxt.phase = i2cms_pkg::PH_WHIGH;
					end
					i2cms_pkg::PH_WHIGH: begin
						st_nxt.scl = 1'b1;
						st_nxt.delay_left = dly2;
						st_nxt.phase = i2cms_pkg::PH_WLOW;
					end
					i2cms_pkg::PH_WLOW: begin
						st_nxt.scl = 1'b0;
						st_nxt.bit_index = bit_inc;
						st_nxt.delay_left = dly2;
						st_nxt.phase = (bit_inc >= i2cms_pkg::BYTE_BITS) ?
							i2cms_pkg::PH_WEND : i2cms_pkg::PH_WBIT;
					end
					i2cms_pkg::PH_WEND: st_nxt.phase = i2cms_pkg::PH_IDLE;
					i2cms_pkg::PH_RLOW: begin
						st_nxt.sda_dir = 1'b0;
						st_nxt.scl = 1'b0;
						st_nxt.delay_left = dly2;
						st_nxt.phase = i2cms_pkg::PH_RHIGH;
					end
					i2cms_pkg::PH_RHIGH: begin
						st_nxt.scl = 1'b1;
						st_nxt.shift_data = {st_nxt.shift_data[6:0], sda_in};
						st_nxt.bit_index = bit_inc;
						st_nxt.delay_left = dly1;
						st_nxt.phase = (bit_inc >= i2cms_pkg::BYTE_BITS) ?
							i2cms_pkg::PH_RK0 : i2cms_pkg::PH_RLOW;
					end
					i2cms_pkg::PH_RK0: begin
						st_nxt.rx = st_nxt.shift_data;
						st_nxt.sda_dir = 1'b1;
						st_nxt.scl = 1'b0;
						st_nxt.sda = !st_nxt.ack_choice;
						st_nxt.delay_left = dly2;
						st_nxt.phase = i2cms_pkg::PH_RK1;
					end
					i2cms_pkg::PH_RK1: begin
						st_nxt.scl = 1'b1;
						st_nxt.delay_left = dly2;
						st_nxt.phase = i2cms_pkg::PH_RK2;
					end
					i2cms_pkg::PH_RK2: begin
						st_nxt.scl = 1'b0;
						st_nxt.phase = i2cms_pkg::PH_IDLE;
					end
					default: st_nxt.phase = i2cms_pkg::PH_IDLE;
				endcase
			end
		end
	end

	// Result fields reflect the updated state
	always_comb begin
		res.scl_level     = st_nxt.scl;
		res.sda_level     = st_nxt.sda;
		res.sda_is_output = st_nxt.sda_dir;
		res.busy          = (st_nxt.phase != i2cms_pkg::PH_IDLE);
		res.done          = active && (st_nxt.phase == i2cms_pkg::PH_IDLE);
		res.rx_byte       = st_nxt.rx;
		res.ack_failed    = st_nxt.ack_fail;
	end

endmodule

// ===== rtl/i2cms_outbuf.sv =====
// Two-entry result buffer between the sequencer and the output channel.
`timescale 1ns / 1ps
module i2cms_outbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  i2cms_pkg::result_t push_data,
	output logic               can_push,
	output logic               out_valid,
	input  logic               out_ready,
	output i2cms_pkg::result_t out_data
);

	i2cms_pkg::result_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign can_push  = (cnt_q != i2cms_pkg::OBUF_DEPTH);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Count tracks transactions on both sides
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("outbuf count missed a push");
	a_cnt_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("outbuf count missed a pop");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("outbuf pointers disagree with count");

endmodule

// ===== rtl/i2c_master_bit_sequencer_unit.sv =====
// Top level of the I2C master bit sequencer: state, config and result buffer.
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+-----------------
//  config  | cfg_we, cfg_index, cfg_wdata                   | write on cfg_we
//  input   | command, tx_byte, send_ack, sda_in             | in_valid/in_ready
//  output  | scl_level .. ack_failed                        | out_valid/out_ready
//
// One tick item is taken per cycle while the buffer has room; its result enters
// the output buffer on the same edge and is shown once older results are taken.
// The rate is set by the single state update between the state registers.
// A two-entry output buffer lets the input keep flowing while one result waits;
// input stalls only when both entries are held. Reset needs no clearing pass.
`timescale 1ns / 1ps
module i2c_master_bit_sequencer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic [7:0] tx_byte,
	input  logic       send_ack,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_level,
	output logic       sda_level,
	output logic       sda_is_output,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rx_byte,
	output logic       ack_failed
);

	logic [7:0]         ticks_per_us_q;
	logic [7:0]         ack_timeout_q;
	i2cms_pkg::state_t  st_q;
	i2cms_pkg::state_t  st_nxt;
	i2cms_pkg::result_t res;
	i2cms_pkg::result_t out_res;
	logic               in_acc;

	assign in_acc = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_us_q <= i2cms_pkg::TICKS_PER_US_RST;
			ack_timeout_q  <= i2cms_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cms_pkg::CFG_TICKS_PER_US: ticks_per_us_q <= cfg_wdata;
				i2cms_pkg::CFG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Tick update logic
	i2cms_step u_step (
		.st           (st_q),
		.ticks_per_us (ticks_per_us_q),
		.ack_timeout  (ack_timeout_q),
		.command      (command),
		.tx_byte      (tx_byte),
		.send_ack     (send_ack),
		.sda_in       (sda_in),
		.st_nxt       (st_nxt),
		.res          (res)
	);

	// Sequencer state advances once per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= i2cms_pkg::PH_IDLE;
			st_q.bit_index  <= '0;
			st_q.shift_data <= '0;
			st_q.delay_left <= '0;
			st_q.poll_count <= '0;
			st_q.ack_choice <= 1'b0;
			st_q.scl        <= 1'b1;
			st_q.sda        <= 1'b1;
			st_q.sda_dir    <= 1'b1;
			st_q.rx         <= '0;
			st_q.ack_fail   <= 1'b0;
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	// Result buffer
	i2cms_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.push_data (res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign scl_level     = out_res.scl_level;
	assign sda_level     = out_res.sda_level;
	assign sda_is_output = out_res.sda_is_output;
	assign busy_res      = out_res.busy;
	assign done_res      = out_res.done;
	assign rx_byte       = out_res.rx_byte;
	assign ack_failed    = out_res.ack_failed;

	// State holds between transactions
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> (st_q == $past(st_q)))
		else $error("sequencer state moved without a transaction");
	// No pending delay while idle
	a_idle_nodly: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == i2cms_pkg::PH_IDLE) |-> (st_q.delay_left == 10'd0))
		else $error("delay left over in idle");
	// Done and busy never both set in one result
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !(res.done && res.busy))
		else $error("done reported while still busy");

endmodule
